### sv/md5_pkg.sv
`default_nettype none

package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out;

    // sequencer steps
    typedef enum logic [2:0] {
        ST_TAKE,
        ST_PAD80,
        ST_PADZ,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_step;

    // datapath operation selected by a control word
    typedef enum logic [2:0] {
        OP_TAKE,
        OP_PAD80,
        OP_PADZ,
        OP_LEN,
        OP_ROUND,
        OP_ADD,
        OP_EMIT
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_END,
        C_AT56,
        C_LEN_LAST,
        C_RND_LAST,
        C_OUT_LAST
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step jmp;
        t_step nxt;
        logic  ret;
    } t_uword;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_START = 6'd56;
    localparam logic [5:0]  LAST_POS = 6'd63;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [1:0]  LAST_WORD_IDX = 2'd3;

    // control store: one word per step
    function automatic t_uword ucode(input t_step s);
        t_uword u;
        case (s)
            ST_TAKE:  u = '{op: OP_TAKE,  cond: C_END,      jmp: ST_PAD80, nxt: ST_TAKE,  ret: 1'b0};
            ST_PAD80: u = '{op: OP_PAD80, cond: C_ALWAYS,   jmp: ST_PADZ,  nxt: ST_PADZ,  ret: 1'b0};
            ST_PADZ:  u = '{op: OP_PADZ,  cond: C_AT56,     jmp: ST_LEN,   nxt: ST_PADZ,  ret: 1'b0};
            ST_LEN:   u = '{op: OP_LEN,   cond: C_LEN_LAST, jmp: ST_EMIT,  nxt: ST_LEN,   ret: 1'b0};
            ST_ROUND: u = '{op: OP_ROUND, cond: C_RND_LAST, jmp: ST_ADD,   nxt: ST_ROUND, ret: 1'b0};
            ST_ADD:   u = '{op: OP_ADD,   cond: C_ALWAYS,   jmp: ST_TAKE,  nxt: ST_TAKE,  ret: 1'b1};
            ST_EMIT:  u = '{op: OP_EMIT,  cond: C_OUT_LAST, jmp: ST_TAKE,  nxt: ST_EMIT,  ret: 1'b0};
            default:  u = '{op: OP_TAKE,  cond: C_END,      jmp: ST_PAD80, nxt: ST_TAKE,  ret: 1'b0};
        endcase
        return u;
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // message word index; only the low four bits of the round matter mod 16
    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] lo;
        logic [3:0] g;
        lo = i[3:0];
        case (i[5:4])
            2'd0:    g = lo;
            2'd1:    g = 4'(lo * 4'd5 + 4'd1);
            2'd2:    g = 4'(lo * 4'd3 + 4'd5);
            2'd3:    g = 4'(lo * 4'd7);
            default: g = lo;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] round_fn(input logic [5:0] i, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (i[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] w;
        w = {v, v} << s;
        return w[63:32];
    endfunction

endpackage

`default_nettype wire

### sv/md5_hash_engine.sv
// one byte per cycle while filling a block; a full block stalls input during compression
// (64 rounds of the shared round unit, then the chaining add)
// end of message: pad byte and zero fill to byte 56, compressing any block that fills,
// 8 length bytes, then compression; 4 digest beats follow, one per cycle unless stalled
// reset (synchronous, active low) loads the initial vector, clears byte and length counts
// and puts the sequencer back at the byte-accept step
`default_nettype none

module md5_hash_engine (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  md5_pkg::t_in     i_in,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output md5_pkg::t_out    o_out
);
    import md5_pkg::*;

    t_step        r_step, n_step;
    t_step        r_ret, n_ret;
    t_uword       uw;

    logic [31:0]  r_chain [4];
    logic [31:0]  r_a, r_b, r_c, r_d;
    logic [31:0]  r_blk [16];
    logic [5:0]   r_cnt;
    logic [60:0]  r_msg;
    logic [5:0]   r_rnd;
    logic [1:0]   r_idx;

    logic         in_acc, out_acc;
    logic         cond_true;
    logic         we;
    logic [7:0]   wbyte;
    logic         full;
    logic [63:0]  bit_len;
    logic [31:0]  t_sum, f_val, nb;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;
    assign bit_len = {r_msg, 3'b000};

    // round unit
    always_comb begin
        f_val = round_fn(r_rnd, r_b, r_c, r_d);
        t_sum = r_a + f_val + r_blk[msg_index(r_rnd)] + round_const(r_rnd);
        nb    = r_b + rotl(t_sum, rot_amount(r_rnd));
    end

    // next step: microcode word, condition, byte write and block-full jump
    always_comb begin
        uw = ucode(r_step);
        case (uw.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_END:      cond_true = in_acc && i_in.end_of_message;
            C_AT56:     cond_true = (r_cnt == LEN_START);
            C_LEN_LAST: cond_true = (r_cnt == LAST_POS);
            C_RND_LAST: cond_true = (r_rnd == LAST_ROUND);
            C_OUT_LAST: cond_true = out_acc && (r_idx == LAST_WORD_IDX);
            default:    cond_true = 1'b0;
        endcase

        case (uw.op)
            OP_TAKE: begin
                we    = in_acc && i_in.byte_present;
                wbyte = i_in.data_byte;
            end
            OP_PAD80: begin
                we    = 1'b1;
                wbyte = PAD_BYTE;
            end
            OP_PADZ: begin
                we    = (r_cnt != LEN_START);
                wbyte = 8'h00;
            end
            OP_LEN: begin
                we    = 1'b1;
                wbyte = bit_len[{r_cnt[2:0], 3'b000} +: 8];
            end
            default: begin
                we    = 1'b0;
                wbyte = 8'h00;
            end
        endcase

        full  = we && (r_cnt == LAST_POS);
        n_ret = r_ret;
        if (full) begin
            // compress now, then carry on where this step would have gone
            n_step = ST_ROUND;
            n_ret  = cond_true ? uw.jmp : uw.nxt;
        end else if (uw.ret) begin
            n_step = r_ret;
        end else begin
            n_step = cond_true ? uw.jmp : uw.nxt;
        end
    end

    // handshake and payload outputs
    always_comb begin
        o_in_stall        = (r_step != ST_TAKE);
        o_out_valid       = (r_step == ST_EMIT);
        o_out.digest_word = r_chain[r_idx];
        o_out.word_index  = r_idx;
        o_out.last_word   = (r_idx == LAST_WORD_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= ST_TAKE;
            r_ret      <= ST_TAKE;
            r_chain[0] <= IV_A;
            r_chain[1] <= IV_B;
            r_chain[2] <= IV_C;
            r_chain[3] <= IV_D;
            r_cnt      <= '0;
            r_msg      <= '0;
            r_rnd      <= '0;
            r_idx      <= '0;
        end else begin
            r_step <= n_step;
            r_ret  <= n_ret;

            if (we) begin
                r_cnt <= r_cnt + 6'd1;
            end
            if (uw.op == OP_TAKE && in_acc && i_in.byte_present) begin
                r_msg <= r_msg + 61'd1;
            end

            if (uw.op == OP_ROUND) begin
                r_rnd <= r_rnd + 6'd1;
            end

            if (uw.op == OP_ADD) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
            end

            if (uw.op == OP_EMIT && out_acc) begin
                r_idx <= r_idx + 2'd1;
                if (r_idx == LAST_WORD_IDX) begin
                    // back to the initial vector for the next message
                    r_chain[0] <= IV_A;
                    r_chain[1] <= IV_B;
                    r_chain[2] <= IV_C;
                    r_chain[3] <= IV_D;
                    r_cnt      <= '0;
                    r_msg      <= '0;
                end
            end
        end
    end

    // block buffer and working words
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_blk[r_cnt[5:2]][{r_cnt[1:0], 3'b000} +: 8] <= wbyte;
        end
        if (uw.op == OP_ROUND) begin
            r_a <= r_d;
            r_b <= nb;
            r_c <= r_b;
            r_d <= r_c;
        end else begin
            // working words track the chaining words outside compression
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end
    end

endmodule

`default_nettype wire
